// ===== design/mite_pkg.sv =====
// Shared opcodes, status codes and stage payload types of the MIPS I-type execute pipeline.
`default_nettype none
package mite_pkg;

    localparam logic [5:0] OP_REGIMM = 6'd1;
    localparam logic [5:0] OP_BEQ    = 6'd4;
    localparam logic [5:0] OP_BNE    = 6'd5;
    localparam logic [5:0] OP_BLEZ   = 6'd6;
    localparam logic [5:0] OP_BGTZ   = 6'd7;
    localparam logic [5:0] OP_ADDI   = 6'd8;
    localparam logic [5:0] OP_ADDIU  = 6'd9;
    localparam logic [5:0] OP_SLTI   = 6'd10;
    localparam logic [5:0] OP_SLTIU  = 6'd11;
    localparam logic [5:0] OP_ANDI   = 6'd12;
    localparam logic [5:0] OP_ORI    = 6'd13;
    localparam logic [5:0] OP_XORI   = 6'd14;
    localparam logic [5:0] OP_LUI    = 6'd15;
    localparam logic [5:0] OP_LB     = 6'd32;
    localparam logic [5:0] OP_LH     = 6'd33;
    localparam logic [5:0] OP_LWL    = 6'd34;
    localparam logic [5:0] OP_LW     = 6'd35;
    localparam logic [5:0] OP_LBU    = 6'd36;
    localparam logic [5:0] OP_LHU    = 6'd37;
    localparam logic [5:0] OP_LWR    = 6'd38;
    localparam logic [5:0] OP_SB     = 6'd40;
    localparam logic [5:0] OP_SH     = 6'd41;
    localparam logic [5:0] OP_SW     = 6'd43;

    localparam logic [4:0] RT_BLTZ   = 5'd0;
    localparam logic [4:0] RT_BGEZ   = 5'd1;
    localparam logic [4:0] RT_BLTZAL = 5'd16;
    localparam logic [4:0] RT_BGEZAL = 5'd17;

    localparam logic [4:0] LINK_REG  = 5'd31;

    localparam logic [1:0] STATUS_OK  = 2'd0;
    localparam logic [1:0] STATUS_OVF = 2'd1;
    localparam logic [1:0] STATUS_INV = 2'd2;

    typedef struct packed {
        logic [5:0]  op;
        logic [4:0]  rtf;
        logic [31:0] rs;
        logic [31:0] rt;
        logic [15:0] imm;
        logic [31:0] mw;
        logic [31:0] ea;
        logic [31:0] target;
        logic [31:0] link;
    } t_s1;

    typedef struct packed {
        logic [5:0]  op;
        logic [4:0]  rtf;
        logic [31:0] ea;
        logic [31:0] target;
        logic [31:0] wb_data;
        logic        taken;
        logic        ovf;
        logic        regimm_ok;
        logic [3:0]  be;
        logic [31:0] sd;
    } t_s2;

    typedef struct packed {
        logic [1:0]  status;
        logic        reg_write;
        logic [4:0]  reg_dest;
        logic [31:0] reg_data;
        logic        branch_taken;
        logic [31:0] branch_target;
        logic [31:0] mem_address;
        logic        mem_read;
        logic        mem_write;
        logic [3:0]  byte_enable;
        logic [31:0] store_data;
    } t_res;

endpackage
`default_nettype wire

// ===== design/mite_addr.sv =====
// Stage one: effective address, branch target and link adders.
`default_nettype none
module mite_addr (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire logic [5:0]      i_op,
    input  wire logic [4:0]      i_rt_field,
    input  wire logic [31:0]     i_rs_value,
    input  wire logic [31:0]     i_rt_value,
    input  wire logic [15:0]     i_imm16,
    input  wire logic [31:0]     i_pc_base,
    input  wire logic [31:0]     i_mem_word,
    output mite_pkg::t_s1        o_s1
);

    logic [31:0]   se;
    mite_pkg::t_s1 n_s1;
    mite_pkg::t_s1 r_s1;

    assign se = {{16{i_imm16[15]}}, i_imm16};

    always_comb begin
        n_s1.op     = i_op;
        n_s1.rtf    = i_rt_field;
        n_s1.rs     = i_rs_value;
        n_s1.rt     = i_rt_value;
        n_s1.imm    = i_imm16;
        n_s1.mw     = i_mem_word;
        n_s1.ea     = i_rs_value + se;
        n_s1.target = i_pc_base + {se[29:0], 2'b00};
        n_s1.link   = i_pc_base + 32'd4;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule
`default_nettype wire

// ===== design/mite_eval.sv =====
// Stage two: compares, overflow, ALU and load data, store lanes.
`default_nettype none
module mite_eval (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire mite_pkg::t_s1   i_s1,
    output mite_pkg::t_s2        o_s2
);

    logic [31:0]   se;
    logic [1:0]    off;
    logic [7:0]    ld_byte;
    logic [15:0]   ld_half;
    logic [31:0]   lwl_data;
    logic [31:0]   lwr_data;
    logic          rs_neg;
    logic          rs_zero;
    mite_pkg::t_s2 n_s2;
    mite_pkg::t_s2 r_s2;

    assign se      = {{16{i_s1.imm[15]}}, i_s1.imm};
    assign off     = i_s1.ea[1:0];
    assign rs_neg  = i_s1.rs[31];
    assign rs_zero = (i_s1.rs == 32'd0);
    assign ld_half = off[1] ? i_s1.mw[15:0] : i_s1.mw[31:16];

    always_comb begin
        unique case (off)
            2'd0: begin
                ld_byte  = i_s1.mw[31:24];
                lwl_data = i_s1.mw;
                lwr_data = {i_s1.rt[31:8], i_s1.mw[31:24]};
            end
            2'd1: begin
                ld_byte  = i_s1.mw[23:16];
                lwl_data = {i_s1.mw[23:0], i_s1.rt[7:0]};
                lwr_data = {i_s1.rt[31:16], i_s1.mw[31:16]};
            end
            2'd2: begin
                ld_byte  = i_s1.mw[15:8];
                lwl_data = {i_s1.mw[15:0], i_s1.rt[15:0]};
                lwr_data = {i_s1.rt[31:24], i_s1.mw[31:8]};
            end
            default: begin
                ld_byte  = i_s1.mw[7:0];
                lwl_data = {i_s1.mw[7:0], i_s1.rt[23:0]};
                lwr_data = i_s1.mw;
            end
        endcase
    end

    always_comb begin
        n_s2.op        = i_s1.op;
        n_s2.rtf       = i_s1.rtf;
        n_s2.ea        = i_s1.ea;
        n_s2.target    = i_s1.target;
        n_s2.ovf       = ~(i_s1.rs[31] ^ se[31]) & (i_s1.rs[31] ^ i_s1.ea[31]);
        n_s2.regimm_ok = (i_s1.rtf == mite_pkg::RT_BLTZ) || (i_s1.rtf == mite_pkg::RT_BGEZ)
                      || (i_s1.rtf == mite_pkg::RT_BLTZAL)
                      || (i_s1.rtf == mite_pkg::RT_BGEZAL);
        n_s2.taken     = 1'b0;
        n_s2.wb_data   = 32'd0;
        n_s2.be        = 4'd0;
        n_s2.sd        = 32'd0;
        unique case (i_s1.op)
            mite_pkg::OP_REGIMM: begin
                n_s2.taken   = i_s1.rtf[0] ? !rs_neg : rs_neg;
                n_s2.wb_data = i_s1.link;
            end
            mite_pkg::OP_BEQ:   n_s2.taken = (i_s1.rs == i_s1.rt);
            mite_pkg::OP_BNE:   n_s2.taken = (i_s1.rs != i_s1.rt);
            mite_pkg::OP_BLEZ:  n_s2.taken = rs_neg || rs_zero;
            mite_pkg::OP_BGTZ:  n_s2.taken = !rs_neg && !rs_zero;
            mite_pkg::OP_ADDI:  n_s2.wb_data = i_s1.ea;
            mite_pkg::OP_ADDIU: n_s2.wb_data = i_s1.ea;
            mite_pkg::OP_SLTI:
                n_s2.wb_data = {31'd0, ($signed(i_s1.rs) < $signed(se))};
            mite_pkg::OP_SLTIU: n_s2.wb_data = {31'd0, (i_s1.rs < se)};
            mite_pkg::OP_ANDI:  n_s2.wb_data = i_s1.rs & {16'd0, i_s1.imm};
            mite_pkg::OP_ORI:   n_s2.wb_data = i_s1.rs | {16'd0, i_s1.imm};
            mite_pkg::OP_XORI:  n_s2.wb_data = i_s1.rs ^ {16'd0, i_s1.imm};
            mite_pkg::OP_LUI:   n_s2.wb_data = {i_s1.imm, 16'd0};
            mite_pkg::OP_LB:    n_s2.wb_data = {{24{ld_byte[7]}}, ld_byte};
            mite_pkg::OP_LBU:   n_s2.wb_data = {24'd0, ld_byte};
            mite_pkg::OP_LH:    n_s2.wb_data = {{16{ld_half[15]}}, ld_half};
            mite_pkg::OP_LHU:   n_s2.wb_data = {16'd0, ld_half};
            mite_pkg::OP_LW:    n_s2.wb_data = i_s1.mw;
            mite_pkg::OP_LWL:   n_s2.wb_data = lwl_data;
            mite_pkg::OP_LWR:   n_s2.wb_data = lwr_data;
            mite_pkg::OP_SB: begin
                unique case (off)
                    2'd0: begin
                        n_s2.be = 4'b1000;
                        n_s2.sd = {i_s1.rt[7:0], 24'd0};
                    end
                    2'd1: begin
                        n_s2.be = 4'b0100;
                        n_s2.sd = {8'd0, i_s1.rt[7:0], 16'd0};
                    end
                    2'd2: begin
                        n_s2.be = 4'b0010;
                        n_s2.sd = {16'd0, i_s1.rt[7:0], 8'd0};
                    end
                    default: begin
                        n_s2.be = 4'b0001;
                        n_s2.sd = {24'd0, i_s1.rt[7:0]};
                    end
                endcase
            end
            mite_pkg::OP_SH: begin
                n_s2.be = off[1] ? 4'b0011 : 4'b1100;
                n_s2.sd = off[1] ? {16'd0, i_s1.rt[15:0]} : {i_s1.rt[15:0], 16'd0};
            end
            mite_pkg::OP_SW: begin
                n_s2.be = 4'b1111;
                n_s2.sd = i_s1.rt;
            end
            default: begin
                n_s2.taken = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule
`default_nettype wire

// ===== design/mite_select.sv =====
// Stage three logic: instruction class decode, field selection and invalid zeroing.
`default_nettype none
module mite_select (
    input  wire mite_pkg::t_s2   i_s2,
    output mite_pkg::t_res       o_res
);

    always_comb begin
        o_res = '0;
        unique case (i_s2.op)
            mite_pkg::OP_REGIMM: begin
                if (i_s2.regimm_ok) begin
                    o_res.branch_target = i_s2.target;
                    o_res.branch_taken  = i_s2.taken;
                    o_res.reg_write     = i_s2.rtf[4];
                    o_res.reg_dest      = i_s2.rtf[4] ? mite_pkg::LINK_REG : 5'd0;
                    o_res.reg_data      = i_s2.rtf[4] ? i_s2.wb_data : 32'd0;
                end else begin
                    o_res.status = mite_pkg::STATUS_INV;
                end
            end
            mite_pkg::OP_BEQ, mite_pkg::OP_BNE, mite_pkg::OP_BLEZ, mite_pkg::OP_BGTZ: begin
                o_res.branch_target = i_s2.target;
                o_res.branch_taken  = i_s2.taken;
            end
            mite_pkg::OP_ADDI: begin
                if (i_s2.ovf) begin
                    o_res.status = mite_pkg::STATUS_OVF;
                end else begin
                    o_res.reg_write = 1'b1;
                    o_res.reg_dest  = i_s2.rtf;
                    o_res.reg_data  = i_s2.wb_data;
                end
            end
            mite_pkg::OP_ADDIU, mite_pkg::OP_SLTI, mite_pkg::OP_SLTIU, mite_pkg::OP_ANDI,
            mite_pkg::OP_ORI, mite_pkg::OP_XORI, mite_pkg::OP_LUI: begin
                o_res.reg_write = 1'b1;
                o_res.reg_dest  = i_s2.rtf;
                o_res.reg_data  = i_s2.wb_data;
            end
            mite_pkg::OP_LB, mite_pkg::OP_LH, mite_pkg::OP_LWL, mite_pkg::OP_LW,
            mite_pkg::OP_LBU, mite_pkg::OP_LHU, mite_pkg::OP_LWR: begin
                o_res.mem_address = i_s2.ea;
                o_res.mem_read    = 1'b1;
                o_res.reg_write   = 1'b1;
                o_res.reg_dest    = i_s2.rtf;
                o_res.reg_data    = i_s2.wb_data;
            end
            mite_pkg::OP_SB, mite_pkg::OP_SH, mite_pkg::OP_SW: begin
                o_res.mem_address = i_s2.ea;
                o_res.mem_write   = 1'b1;
                o_res.byte_enable = i_s2.be;
                o_res.store_data  = i_s2.sd;
            end
            default: begin
                o_res.status = mite_pkg::STATUS_INV;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/mips_i_type_execute.sv =====
// Top level of the three-stage MIPS I-type execute pipeline.
//
// Input channel: i_valid with the instruction fields, o_stall back to the
// sender; a beat moves at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid with the result fields, i_stall from the receiver;
// a beat moves at a rising edge with o_valid high and i_stall low.
// A beat taken in passes through the stage-one and stage-two registers to the
// output register. Throughput: one beat per cycle while i_stall stays low.
// Stage one holds the address, branch target and link adders, stage two the
// compares, overflow, ALU and load merge, stage three the class decode and
// the output register.
// A stage with no valid beat takes a new one even while a later stage is
// stalled, so bubbles close up. While i_stall holds a valid output, that
// output holds; o_stall rises only when all three stages are full.
// Reset (i_rst_n low at an edge) empties every stage; no beat is lost or
// repeated across a stall.
`default_nettype none
module mips_i_type_execute (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output wire logic        o_stall,
    input  wire logic [5:0]  i_op,
    input  wire logic [4:0]  i_rt_field,
    input  wire logic [31:0] i_rs_value,
    input  wire logic [31:0] i_rt_value,
    input  wire logic [15:0] i_imm16,
    input  wire logic [31:0] i_pc_base,
    input  wire logic [31:0] i_mem_word,
    output wire logic        o_valid,
    input  wire logic        i_stall,
    output wire logic [1:0]  o_status,
    output wire logic        o_reg_write,
    output wire logic [4:0]  o_reg_dest,
    output wire logic [31:0] o_reg_data,
    output wire logic        o_branch_taken,
    output wire logic [31:0] o_branch_target,
    output wire logic [31:0] o_mem_address,
    output wire logic        o_mem_read,
    output wire logic        o_mem_write,
    output wire logic [3:0]  o_byte_enable,
    output wire logic [31:0] o_store_data
);

    logic           r_v1;
    logic           r_v2;
    logic           r_v3;
    logic           n_v1;
    logic           n_v2;
    logic           n_v3;
    logic           adv1;
    logic           adv2;
    logic           adv3;
    mite_pkg::t_s1  s1;
    mite_pkg::t_s2  s2;
    mite_pkg::t_res n_res;
    mite_pkg::t_res r_res;

    assign adv3 = !r_v3 || !i_stall;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;

    assign n_v1 = adv1 ? i_valid : r_v1;
    assign n_v2 = adv2 ? r_v1 : r_v2;
    assign n_v3 = adv3 ? r_v2 : r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

    mite_addr u_addr (
        .i_clk      (i_clk),
        .i_en       (adv1),
        .i_op       (i_op),
        .i_rt_field (i_rt_field),
        .i_rs_value (i_rs_value),
        .i_rt_value (i_rt_value),
        .i_imm16    (i_imm16),
        .i_pc_base  (i_pc_base),
        .i_mem_word (i_mem_word),
        .o_s1       (s1)
    );

    mite_eval u_eval (
        .i_clk (i_clk),
        .i_en  (adv2),
        .i_s1  (s1),
        .o_s2  (s2)
    );

    mite_select u_select (
        .i_s2  (s2),
        .o_res (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_res <= n_res;
        end
    end

    assign o_stall         = !adv1;
    assign o_valid         = r_v3;
    assign o_status        = r_res.status;
    assign o_reg_write     = r_res.reg_write;
    assign o_reg_dest      = r_res.reg_dest;
    assign o_reg_data      = r_res.reg_data;
    assign o_branch_taken  = r_res.branch_taken;
    assign o_branch_target = r_res.branch_target;
    assign o_mem_address   = r_res.mem_address;
    assign o_mem_read      = r_res.mem_read;
    assign o_mem_write     = r_res.mem_write;
    assign o_byte_enable   = r_res.byte_enable;
    assign o_store_data    = r_res.store_data;

    a_no_stall_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output side is free");

    a_invalid_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == mite_pkg::STATUS_INV)) |->
        (!o_reg_write && !o_mem_read && !o_mem_write && !o_branch_taken))
        else $error("invalid instruction has side effects");

    a_store_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_mem_write) |-> (!o_reg_write && !o_mem_read && (o_byte_enable != 4'd0)))
        else $error("store beat with bad lanes or write-back");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3 && i_stall))
        else $error("input stalled with an empty stage");

endmodule
`default_nettype wire

// ===== tb/exec_check_pkg.sv =====
// Instruction beat type and scoreboard with the expected-result predictor for the I-type execute stage.
package exec_check_pkg;
    import mite_pkg::*;

    typedef struct packed {
        logic [5:0]  op;
        logic [4:0]  rt_field;
        logic [31:0] rs_value;
        logic [31:0] rt_value;
        logic [15:0] imm16;
        logic [31:0] pc_base;
        logic [31:0] mem_word;
    } t_instr;

    class exec_scoreboard;
        t_res pending[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        function t_res execute(t_instr in);
            t_res        r;
            logic [31:0] se;
            logic [31:0] target;
            logic [31:0] ea;
            logic [31:0] sum;
            logic [31:0] keep;
            logic [1:0]  off;
            logic [4:0]  sh;
            logic [4:0]  lsh;
            logic [7:0]  b;
            logic [15:0] h;
            r = '0;
            se = {{16{in.imm16[15]}}, in.imm16};
            target = in.pc_base + (se << 2);
            ea = in.rs_value + se;
            off = ea[1:0];
            sh = {~off, 3'b000};
            lsh = {off, 3'b000};
            case (in.op)
                OP_REGIMM: begin
                    r.branch_target = target;
                    if (in.rt_field == RT_BLTZ || in.rt_field == RT_BLTZAL) begin
                        r.branch_taken = in.rs_value[31];
                    end else if (in.rt_field == RT_BGEZ || in.rt_field == RT_BGEZAL) begin
                        r.branch_taken = ~in.rs_value[31];
                    end else begin
                        r.status = STATUS_INV;
                    end
                    if (in.rt_field == RT_BLTZAL || in.rt_field == RT_BGEZAL) begin
                        r.reg_write = 1'b1;
                        r.reg_dest = LINK_REG;
                        r.reg_data = in.pc_base + 32'd4;
                    end
                end
                OP_BEQ: begin
                    r.branch_target = target;
                    r.branch_taken = (in.rs_value == in.rt_value);
                end
                OP_BNE: begin
                    r.branch_target = target;
                    r.branch_taken = (in.rs_value != in.rt_value);
                end
                OP_BLEZ: begin
                    r.branch_target = target;
                    r.branch_taken = in.rs_value[31] || (in.rs_value == 32'd0);
                end
                OP_BGTZ: begin
                    r.branch_target = target;
                    r.branch_taken = !in.rs_value[31] && (in.rs_value != 32'd0);
                end
                OP_ADDI: begin
                    sum = in.rs_value + se;
                    if (in.rs_value[31] == se[31] && sum[31] != in.rs_value[31]) begin
                        r.status = STATUS_OVF;
                    end else begin
                        r.reg_write = 1'b1;
                        r.reg_dest = in.rt_field;
                        r.reg_data = sum;
                    end
                end
                OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI: begin
                    r.reg_write = 1'b1;
                    r.reg_dest = in.rt_field;
                    case (in.op)
                        OP_ADDIU: r.reg_data = in.rs_value + se;
                        OP_SLTI:  r.reg_data = {31'd0, $signed(in.rs_value) < $signed(se)};
                        OP_SLTIU: r.reg_data = {31'd0, in.rs_value < se};
                        OP_ANDI:  r.reg_data = in.rs_value & {16'd0, in.imm16};
                        OP_ORI:   r.reg_data = in.rs_value | {16'd0, in.imm16};
                        OP_XORI:  r.reg_data = in.rs_value ^ {16'd0, in.imm16};
                        default:  r.reg_data = {in.imm16, 16'd0};
                    endcase
                end
                OP_LB, OP_LH, OP_LWL, OP_LW, OP_LBU, OP_LHU, OP_LWR: begin
                    r.mem_address = ea;
                    r.mem_read = 1'b1;
                    r.reg_write = 1'b1;
                    r.reg_dest = in.rt_field;
                    b = 8'(in.mem_word >> sh);
                    h = off[1] ? in.mem_word[15:0] : in.mem_word[31:16];
                    case (in.op)
                        OP_LB:  r.reg_data = {{24{b[7]}}, b};
                        OP_LBU: r.reg_data = {24'd0, b};
                        OP_LH:  r.reg_data = {{16{h[15]}}, h};
                        OP_LHU: r.reg_data = {16'd0, h};
                        OP_LW:  r.reg_data = in.mem_word;
                        OP_LWL: begin
                            keep = 32'h00FF_FFFF >> sh;
                            r.reg_data = (in.mem_word << lsh) | (in.rt_value & keep);
                        end
                        default: begin
                            keep = 32'hFFFF_FF00 << lsh;
                            r.reg_data = (in.mem_word >> sh) | (in.rt_value & keep);
                        end
                    endcase
                end
                OP_SB: begin
                    r.mem_address = ea;
                    r.mem_write = 1'b1;
                    r.byte_enable = 4'b0001 << ~off;
                    r.store_data = {24'd0, in.rt_value[7:0]} << sh;
                end
                OP_SH: begin
                    r.mem_address = ea;
                    r.mem_write = 1'b1;
                    if (off[1]) begin
                        r.byte_enable = 4'b0011;
                        r.store_data = {16'd0, in.rt_value[15:0]};
                    end else begin
                        r.byte_enable = 4'b1100;
                        r.store_data = {in.rt_value[15:0], 16'd0};
                    end
                end
                OP_SW: begin
                    r.mem_address = ea;
                    r.mem_write = 1'b1;
                    r.byte_enable = 4'b1111;
                    r.store_data = in.rt_value;
                end
                default: r.status = STATUS_INV;
            endcase
            if (r.status == STATUS_INV) begin
                r = '0;
                r.status = STATUS_INV;
            end
            return r;
        endfunction

        function void note_instr(t_instr in);
            pending.push_back(execute(in));
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s expected %0h actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (pending.size() == 0) begin
                $error("result beat with no instruction outstanding");
                errors++;
                return;
            end
            want = pending.pop_front();
            check_field("status", want.status, got.status);
            check_field("reg_write", want.reg_write, got.reg_write);
            check_field("reg_dest", want.reg_dest, got.reg_dest);
            check_field("reg_data", want.reg_data, got.reg_data);
            check_field("branch_taken", want.branch_taken, got.branch_taken);
            check_field("branch_target", want.branch_target, got.branch_target);
            check_field("mem_address", want.mem_address, got.mem_address);
            check_field("mem_read", want.mem_read, got.mem_read);
            check_field("mem_write", want.mem_write, got.mem_write);
            check_field("byte_enable", want.byte_enable, got.byte_enable);
            check_field("store_data", want.store_data, got.store_data);
        endfunction
    endclass

endpackage

// ===== tb/tb.sv =====
// Top-level testbench for the I-type execute pipeline: directed and random instruction beats.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mite_pkg::*;
    import exec_check_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int IDLE_PCT      = 35;
    localparam int RANDOM_INSTRS = 550;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_stall = 1'b0;
    t_instr      instr_q = '0;
    wire logic   o_stall;
    wire logic   o_valid;
    wire logic [1:0]  o_status;
    wire logic        o_reg_write;
    wire logic [4:0]  o_reg_dest;
    wire logic [31:0] o_reg_data;
    wire logic        o_branch_taken;
    wire logic [31:0] o_branch_target;
    wire logic [31:0] o_mem_address;
    wire logic        o_mem_read;
    wire logic        o_mem_write;
    wire logic [3:0]  o_byte_enable;
    wire logic [31:0] o_store_data;
    t_res        result_w;

    bit             calm = 1'b0;
    int             cycle_count = 0;
    exec_scoreboard sb;

    logic [5:0] legal_ops [23] = '{OP_REGIMM, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI,
        OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI, OP_LB, OP_LH,
        OP_LWL, OP_LW, OP_LBU, OP_LHU, OP_LWR, OP_SB, OP_SH, OP_SW};
    logic [4:0] branch_kinds [4] = '{RT_BLTZ, RT_BGEZ, RT_BLTZAL, RT_BGEZAL};

    assign result_w = {o_status, o_reg_write, o_reg_dest, o_reg_data, o_branch_taken,
                       o_branch_target, o_mem_address, o_mem_read, o_mem_write,
                       o_byte_enable, o_store_data};

    mips_i_type_execute DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (instr_q.op),
        .i_rt_field     (instr_q.rt_field),
        .i_rs_value     (instr_q.rs_value),
        .i_rt_value     (instr_q.rt_value),
        .i_imm16        (instr_q.imm16),
        .i_pc_base      (instr_q.pc_base),
        .i_mem_word     (instr_q.mem_word),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_reg_write    (o_reg_write),
        .o_reg_dest     (o_reg_dest),
        .o_reg_data     (o_reg_data),
        .o_branch_taken (o_branch_taken),
        .o_branch_target(o_branch_target),
        .o_mem_address  (o_mem_address),
        .o_mem_read     (o_mem_read),
        .o_mem_write    (o_mem_write),
        .o_byte_enable  (o_byte_enable),
        .o_store_data   (o_store_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_instr(instr_q);
            if (o_valid && !i_stall) sb.check_result(result_w);
        end
    end

    function automatic t_instr make_instr(logic [5:0] op, logic [4:0] rtf, logic [31:0] rs,
                                          logic [31:0] rt, logic [15:0] imm,
                                          logic [31:0] pc, logic [31:0] mw);
        t_instr it;
        it = '{op, rtf, rs, rt, imm, pc, mw};
        return it;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_instr random_instr();
        t_instr it;
        if ($urandom_range(99) < 88) it.op = legal_ops[$urandom_range(22)];
        else it.op = 6'($urandom_range(63));
        it.rt_field = 5'($urandom_range(31));
        if (it.op == OP_REGIMM && $urandom_range(9) < 8) begin
            it.rt_field = branch_kinds[$urandom_range(3)];
        end
        it.rs_value = pick_word();
        it.rt_value = ($urandom_range(3) == 0) ? it.rs_value : pick_word();
        case ($urandom_range(9))
            0: it.imm16 = 16'h0000;
            1: it.imm16 = 16'hFFFF;
            2: it.imm16 = 16'h7FFF;
            3: it.imm16 = 16'h8000;
            default: it.imm16 = 16'($urandom);
        endcase
        it.pc_base = pick_word();
        it.mem_word = $urandom;
        return it;
    endfunction

    task automatic send_instr(t_instr it);
        int gap;
        gap = 0;
        while (!calm && $urandom_range(99) < IDLE_PCT) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        instr_q <= it;
        do @(posedge i_clk); while (o_stall);
    endtask

    initial begin
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_instr(make_instr(OP_REGIMM, RT_BLTZ, 32'h8000_0000, 0, 16'h0004, 32'h100, 0));
        send_instr(make_instr(OP_REGIMM, RT_BGEZ, 32'h7FFF_FFFF, 0, 16'h8000, 32'h0, 0));
        send_instr(make_instr(OP_REGIMM, RT_BLTZAL, 32'hFFFF_FFFF, 0, 16'hFFFF,
                              32'hFFFF_FFFC, 0));
        send_instr(make_instr(OP_REGIMM, RT_BGEZAL, 32'h0, 0, 16'h7FFF, 32'h1000, 0));
        send_instr(make_instr(OP_REGIMM, 5'd5, 32'h1234, 0, 16'h10, 32'h2000, 0));
        send_instr(make_instr(OP_BEQ, 5'd3, 32'hDEAD_BEEF, 32'hDEAD_BEEF, 16'hFFFE,
                              32'h400, 0));
        send_instr(make_instr(OP_BNE, 5'd4, 32'h1, 32'h2, 16'h0001, 32'h7FFF_FFFC, 0));
        send_instr(make_instr(OP_BLEZ, 5'd7, 32'h0, 0, 16'h0020, 32'h800, 0));
        send_instr(make_instr(OP_BGTZ, 5'd0, 32'h1, 0, 16'h8001, 32'h800, 0));
        send_instr(make_instr(OP_ADDI, 5'd8, 32'h7FFF_FFFF, 0, 16'h0001, 0, 0));
        send_instr(make_instr(OP_ADDI, 5'd9, 32'h8000_0000, 0, 16'hFFFF, 0, 0));
        send_instr(make_instr(OP_ADDIU, 5'd0, 32'h7FFF_FFFF, 0, 16'h0001, 0, 0));
        send_instr(make_instr(OP_SLTI, 5'd10, 32'h8000_0000, 0, 16'h7FFF, 0, 0));
        send_instr(make_instr(OP_SLTIU, 5'd11, 32'h5, 0, 16'hFFFF, 0, 0));
        send_instr(make_instr(OP_ANDI, 5'd12, 32'hFFFF_FFFF, 0, 16'hA5A5, 0, 0));
        send_instr(make_instr(OP_ORI, 5'd13, 32'h8000_0000, 0, 16'hFFFF, 0, 0));
        send_instr(make_instr(OP_XORI, 5'd14, 32'hFFFF_0F0F, 0, 16'hFFFF, 0, 0));
        send_instr(make_instr(OP_LUI, 5'd31, 32'h0, 0, 16'hFFFF, 0, 0));
        send_instr(make_instr(OP_LB, 5'd1, 32'h1003, 0, 16'h0, 0, 32'h1234_56F0));
        send_instr(make_instr(OP_LH, 5'd2, 32'h2001, 0, 16'h0, 0, 32'h9ABC_1234));
        send_instr(make_instr(OP_LWL, 5'd3, 32'h10, 32'hAABB_CCDD, 16'hFFF1, 0,
                              32'h1122_3344));
        send_instr(make_instr(OP_LW, 5'd4, 32'hFFFF_FFFE, 0, 16'h0, 0, 32'hCAFE_F00D));
        send_instr(make_instr(OP_LBU, 5'd5, 32'h0, 0, 16'h0, 0, 32'hFF00_0000));
        send_instr(make_instr(OP_LHU, 5'd6, 32'h3, 0, 16'h0, 0, 32'h0000_8001));
        send_instr(make_instr(OP_LWR, 5'd7, 32'h7FFF_FFFE, 32'hAABB_CCDD, 16'h0004, 0,
                              32'h1122_3344));
        send_instr(make_instr(OP_SB, 5'd8, 32'h100, 32'h1234_5687, 16'h0, 0, 0));
        send_instr(make_instr(OP_SH, 5'd9, 32'h3, 32'hFFFF_8001, 16'h0, 0, 0));
        send_instr(make_instr(OP_SW, 5'd10, 32'hFFFF_FFFF, 32'h8765_4321, 16'h0002, 0, 0));
        send_instr(make_instr(6'd63, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                              32'hFFFF_FFFF, 32'hFFFF_FFFF));

        for (int k = 0; k < RANDOM_INSTRS; k++) begin
            calm = (k >= 200 && k < 320);
            send_instr(random_instr());
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        do @(posedge i_clk); while (sb.pending.size() != 0);
        repeat (12) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/mite_pkg.sv
design/mite_addr.sv
design/mite_eval.sv
design/mite_select.sv
design/mips_i_type_execute.sv
tb/exec_check_pkg.sv
tb/tb.sv
